// ===== hdl/kpd_pkg.sv =====
// Package for the key press duration classifier: phase and event codes, counter constants.
package kpd_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int TICK_WIDTH  = 16;
    localparam int CMP_WIDTH   = (COUNT_WIDTH > TICK_WIDTH) ? COUNT_WIDTH : TICK_WIDTH;

    localparam logic [COUNT_WIDTH-1:0] CountMax = {COUNT_WIDTH{1'b1}};

    localparam logic [TICK_WIDTH-1:0] LongTicksReset  = TICK_WIDTH'(100);
    localparam logic [TICK_WIDTH-1:0] VlongTicksReset = TICK_WIDTH'(300);
    localparam logic [TICK_WIDTH-1:0] BlockTicksReset = TICK_WIDTH'(100);

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_PRE   = 3'd1,
        PH_HELD  = 3'd2,
        PH_LONG  = 3'd3,
        PH_VLONG = 3'd4,
        PH_BLOCK = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_SHORT   = 3'd1,
        EV_LONG    = 3'd2,
        EV_HOLDING = 3'd3,
        EV_VLONG   = 3'd4
    } event_t;

    typedef enum logic [1:0] {
        REG_LONG_TICKS  = 2'd0,
        REG_VLONG_TICKS = 2'd1,
        REG_BLOCK_TICKS = 2'd2
    } reg_index_t;

endpackage

// ===== hdl/key_press_duration_classifier.sv =====
// A result word is registered in the output or skid register. Throughput: one readout
// per cycle while skid is empty; the phase and hold counter update in a single pass.
// An output register plus one skid register let one finished word wait while the next
// readout is taken. Reset (rst_n low, asynchronous) returns the phase to idle, clears
// the hold counter and empties both result registers; thresholds reload to 100/300/100.
module key_press_duration_classifier
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // [0] key_level, [7:1] zero
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // [2:0] press_event, [5:3] key_phase, [7:6] zero
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [kpd_pkg::TICK_WIDTH-1:0] cfg_data
);
    import kpd_pkg::*;

    logic [TICK_WIDTH-1:0]  long_ticks_reg;
    logic [TICK_WIDTH-1:0]  vlong_ticks_reg;
    logic [TICK_WIDTH-1:0]  block_ticks_reg;

    phase_t                 phase_reg;
    phase_t                 phase_next;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic [COUNT_WIDTH-1:0] count_next;
    event_t                 event_next;

    logic                   out_valid_reg;
    logic [5:0]             out_data_reg;
    logic                   skid_valid_reg;
    logic [5:0]             skid_data_reg;

    logic                   accept;
    logic                   out_free;
    logic                   pressed;
    logic [COUNT_WIDTH-1:0] count_inc;
    logic [CMP_WIDTH-1:0]   count_cmp;
    logic [CMP_WIDTH-1:0]   long_cmp;
    logic [CMP_WIDTH-1:0]   vlong_cmp;
    logic [CMP_WIDTH-1:0]   block_cmp;
    logic [5:0]             result;

    assign cfg_ready = 1'b1;
    assign s_tready  = !skid_valid_reg;
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {2'b00, out_data_reg};

    assign pressed   = !s_tdata[0];
    assign count_inc = (count_reg == CountMax) ? count_reg : count_reg + 1'b1;
    assign long_cmp  = CMP_WIDTH'(long_ticks_reg);
    assign vlong_cmp = CMP_WIDTH'(vlong_ticks_reg);
    assign block_cmp = CMP_WIDTH'(block_ticks_reg);
    assign count_cmp = CMP_WIDTH'(count_inc);
    assign result    = {3'(phase_next), 3'(event_next)};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_ticks_reg  <= LongTicksReset;
            vlong_ticks_reg <= VlongTicksReset;
            block_ticks_reg <= BlockTicksReset;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_LONG_TICKS:  long_ticks_reg  <= cfg_data;
                REG_VLONG_TICKS: vlong_ticks_reg <= cfg_data;
                REG_BLOCK_TICKS: block_ticks_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            count_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
        end
    end

    // At most one phase transition per readout.
    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        event_next = EV_NONE;
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (pressed)
                    phase_next = PH_PRE;
            end
            PH_PRE:
            begin
                phase_next = pressed ? PH_HELD : PH_IDLE;
            end
            PH_HELD:
            begin
                if (pressed)
                begin
                    count_next = count_inc;
                    if (count_cmp > long_cmp)
                        phase_next = PH_LONG;
                end
                else
                begin
                    event_next = EV_SHORT;
                    phase_next = PH_IDLE;
                    count_next = '0;
                end
            end
            PH_LONG:
            begin
                if (pressed)
                begin
                    count_next = count_inc;
                    if (count_cmp > vlong_cmp)
                        phase_next = PH_VLONG;
                end
                else
                begin
                    event_next = EV_LONG;
                    phase_next = PH_IDLE;
                    count_next = '0;
                end
            end
            PH_VLONG:
            begin
                if (pressed)
                    count_next = CountMax;
                else
                begin
                    event_next = EV_VLONG;
                    phase_next = PH_BLOCK;
                    count_next = '0;
                end
            end
            PH_BLOCK:
            begin
                // A saturated counter ends the blocking as if the limit were reached.
                if ((CMP_WIDTH'(count_reg) < block_cmp) && (count_reg != CountMax))
                    count_next = count_inc;
                else
                begin
                    phase_next = PH_IDLE;
                    count_next = '0;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
                count_next = '0;
            end
        endcase
        if (pressed && (phase_next == PH_LONG || phase_next == PH_VLONG))
            event_next = EV_HOLDING;
    end

    // The skid register catches a result word while the output word is stalled.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg || accept;
            skid_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
                out_data_reg <= skid_data_reg;
            else if (accept)
                out_data_reg <= result;
        end
        else if (accept)
        begin
            skid_data_reg <= result;
        end
    end

endmodule

// ===== tb/sv/key_press_duration_classifier_tb.sv =====
// Self-checking testbench for the key press duration classifier.
module key_press_duration_classifier_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import kpd_pkg::*;

    // Index past the end of the register list; writes to it must be ignored.
    localparam logic [1:0] REG_UNUSED = 2'd3;

    // Hand-made sequence, sent from the top bit down, for thresholds 2/4/2.
    localparam logic [23:0] DirectedKeys = 24'b101001_00000000_1_101_00000_1;

    typedef struct packed {
        event_t ev;
        phase_t ph;
    } key_result_t;

    class key_event_checker;
        logic [TICK_WIDTH-1:0]  long_ticks;
        logic [TICK_WIDTH-1:0]  vlong_ticks;
        logic [TICK_WIDTH-1:0]  block_ticks;
        phase_t                 phase;
        logic [COUNT_WIDTH-1:0] hold_count;
        key_result_t            expected_events[$];
        int                     errors;

        function new();
            long_ticks  = LongTicksReset;
            vlong_ticks = VlongTicksReset;
            block_ticks = BlockTicksReset;
            phase       = PH_IDLE;
            hold_count  = '0;
            errors      = 0;
        endfunction

        function void write_reg(logic [1:0] index, logic [TICK_WIDTH-1:0] value);
            case (index)
                REG_LONG_TICKS:  long_ticks  = value;
                REG_VLONG_TICKS: vlong_ticks = value;
                REG_BLOCK_TICKS: block_ticks = value;
                default: ;
            endcase
        endfunction

        function logic [COUNT_WIDTH-1:0] bump(logic [COUNT_WIDTH-1:0] count);
            return (count == CountMax) ? CountMax : count + 1'b1;
        endfunction

        // Advances the predicted phase by one readout and queues the event it gives.
        function void note_readout(logic key_level);
            logic        pressed;
            event_t      ev;
            key_result_t res;
            pressed = (key_level == 1'b0);
            ev = EV_NONE;
            case (phase)
                PH_IDLE:
                    if (pressed)
                        phase = PH_PRE;
                PH_PRE:
                    if (pressed)
                        phase = PH_HELD;
                    else
                        phase = PH_IDLE;
                PH_HELD:
                    if (pressed)
                    begin
                        hold_count = bump(hold_count);
                        if (hold_count > long_ticks)
                            phase = PH_LONG;
                    end
                    else
                    begin
                        ev = EV_SHORT;
                        phase = PH_IDLE;
                        hold_count = '0;
                    end
                PH_LONG:
                    if (pressed)
                    begin
                        hold_count = bump(hold_count);
                        if (hold_count > vlong_ticks)
                            phase = PH_VLONG;
                    end
                    else
                    begin
                        ev = EV_LONG;
                        phase = PH_IDLE;
                        hold_count = '0;
                    end
                PH_VLONG:
                    if (pressed)
                        hold_count = CountMax;
                    else
                    begin
                        ev = EV_VLONG;
                        phase = PH_BLOCK;
                        hold_count = '0;
                    end
                PH_BLOCK:
                    if (hold_count < block_ticks && hold_count < CountMax)
                        hold_count = hold_count + 1'b1;
                    else
                    begin
                        phase = PH_IDLE;
                        hold_count = '0;
                    end
                default:
                begin
                    phase = PH_IDLE;
                    hold_count = '0;
                end
            endcase
            if (pressed && (phase == PH_LONG || phase == PH_VLONG))
                ev = EV_HOLDING;
            res.ev = ev;
            res.ph = phase;
            expected_events.push_back(res);
        endfunction

        function void check_event(logic [7:0] word);
            key_result_t want;
            if (expected_events.size() == 0)
            begin
                $error("result word %h arrived with no readout outstanding", word);
                errors++;
                return;
            end
            want = expected_events.pop_front();
            if (word[2:0] !== want.ev)
            begin
                $error("press_event: expected %0d, got %0d", want.ev, word[2:0]);
                errors++;
            end
            if (word[5:3] !== want.ph)
            begin
                $error("key_phase: expected %0d, got %0d", want.ph, word[5:3]);
                errors++;
            end
        endfunction

        function int pending();
            return expected_events.size();
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;     // [0] key_level, [7:1] zero
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [7:0]            m_tdata;     // [2:0] press_event, [5:3] key_phase, [7:6] zero
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [1:0]            cfg_index;
    logic [TICK_WIDTH-1:0] cfg_data;

    key_event_checker score = new();
    int src_idle_pct  = 19;
    int sink_idle_pct = 82;

    key_press_duration_classifier DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= sink_idle_pct);

    // Values read here are those from before the edge, as the block saw them.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                score.note_readout(s_tdata[0]);
            if (m_tvalid && m_tready)
                score.check_event(m_tdata);
        end
    end

    // Leaves s_tvalid high after the handshake so that back-to-back words need no toggle.
    task automatic send_key(input logic level);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, level};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (score.pending() != 0);
    endtask

    task automatic configure(input logic [TICK_WIDTH-1:0] long_t,
                             input logic [TICK_WIDTH-1:0] vlong_t,
                             input logic [TICK_WIDTH-1:0] block_t);
        logic [1:0]            index_list [4];
        logic [TICK_WIDTH-1:0] value_list [4];
        drain_results();
        index_list = '{REG_UNUSED, REG_LONG_TICKS, REG_VLONG_TICKS, REG_BLOCK_TICKS};
        value_list = '{TICK_WIDTH'($urandom), long_t, vlong_t, block_t};
        for (int k = 0; k < 4; k++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= index_list[k];
            cfg_data  <= value_list[k];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            score.write_reg(index_list[k], value_list[k]);
        end
        cfg_valid <= 1'b0;
    endtask

    // Mostly whole presses sized around the current thresholds, with some noise between.
    task automatic random_presses(input int budget);
        int sent;
        int hold;
        int rel;
        int lt;
        int vt;
        int bt;
        int top;
        sent = 0;
        while (sent < budget)
        begin
            lt  = int'(score.long_ticks);
            vt  = int'(score.vlong_ticks);
            bt  = int'(score.block_ticks);
            top = (lt > vt) ? lt : vt;
            if ($urandom_range(9) < 2)
            begin
                hold = $urandom_range(1, 8);
                repeat (hold)
                    send_key(1'($urandom_range(1)));
                sent += hold;
            end
            else
            begin
                case ($urandom_range(3))
                    0:       hold = $urandom_range(0, 3);
                    1:       hold = lt + $urandom_range(1, 4);
                    2:       hold = top + $urandom_range(3, 6);
                    default: hold = $urandom_range(0, top + 6);
                endcase
                if ($urandom_range(3) == 0)
                    rel = bt + $urandom_range(0, 3);
                else
                    rel = $urandom_range(1, 3);
                repeat (hold)
                    send_key(1'b0);
                repeat (rel)
                    send_key(1'b1);
                sent += hold + rel;
            end
            if ($urandom_range(49) == 0)
                drain_results();
        end
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= 8'd0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_LONG_TICKS;
        cfg_data  <= '0;
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset thresholds first, then the hand-made sequence.
        random_presses(400);
        configure(16'd2, 16'd4, 16'd2);
        for (int i = 23; i >= 0; i--)
            send_key(DirectedKeys[i]);
        configure(16'd0, 16'd0, 16'd0);
        random_presses(250);

        src_idle_pct  = 82;
        sink_idle_pct = 19;
        configure(16'd3, 16'd7, 16'd4);
        random_presses(300);
        configure(16'd10, 16'd5, 16'd2);
        random_presses(250);

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        repeat (2)
        begin
            configure(TICK_WIDTH'($urandom_range(20)), TICK_WIDTH'($urandom_range(20)),
                      TICK_WIDTH'($urandom_range(20)));
            random_presses(250);
        end

        // Thresholds at the top of the range: the press stays held.
        configure(16'hFFFF, 16'hFFFF, 16'd0);
        repeat (10)
            send_key(1'b1);
        repeat (40)
            send_key(1'b0);
        repeat (3)
            send_key(1'b1);

        // Longest blocking: the key stays ignored to the end of the run.
        configure(16'd1, 16'd2, 16'hFFFF);
        repeat (10)
            send_key(1'b1);
        repeat (6)
            send_key(1'b0);
        send_key(1'b1);
        repeat (40)
            send_key(1'($urandom_range(1)));
        repeat (4)
            send_key(1'b0);
        send_key(1'b1);

        drain_results();
        repeat (10)
            @(posedge clk);
        if (score.pending() != 0)
        begin
            $error("%0d result words never arrived", score.pending());
            score.errors++;
        end
        if (score.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #6_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/kpd_pkg.sv
hdl/key_press_duration_classifier.sv
tb/sv/key_press_duration_classifier_tb.sv
